@@ rtl/lp2c_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_pkg: shared types and constants for the lidar polar-to-cartesian unit
// Widths, CORDIC arctangent table, register indexes and pipeline tag.
// ----------------------------------------------------------------------------
package lp2c_pkg;

    localparam int RW  = 24;   // range, Q8.16 unsigned
    localparam int ZW  = 32;   // binary angle
    localparam int XW  = 44;   // CORDIC datapath, 16 extra fraction bits plus headroom
    localparam int PW  = 40;   // gain-scaled start vector magnitude
    localparam int OW  = 25;   // output coordinate, Q8.16 signed
    localparam int TW  = XW - 16;  // width after dropping the extra fraction bits

    localparam logic [31:0] GAIN_Q32  = 32'h9B74_EDA8;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [TW-1:0] OUT_LIMIT = TW'(16777215);

    typedef enum logic [1:0] {
        REG_START_ANGLE = 2'd0,
        REG_ANGLE_STEP  = 2'd1,
        REG_MIN_RANGE   = 2'd2,
        REG_MAX_RANGE   = 2'd3
    } lp2c_reg_t;

    typedef struct packed {
        logic [ZW-1:0] start_angle;
        logic [ZW-1:0] angle_step;
        logic [RW-1:0] min_range;
        logic [RW-1:0] max_range;
    } lp2c_cfg_t;

    // Sideband carried alongside each sample through the pipeline
    typedef struct packed {
        logic pt_ok;
        logic last;
    } lp2c_tag_t;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    function automatic logic [31:0] lp2c_atan(input logic [4:0] idx);
        return ATAN_TAB[idx];
    endfunction

endpackage

@@ rtl/lp2c_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_front: beam angle tracking, range window check and CORDIC start vector
// Two stages: gain multiply, then quadrant fold into [-pi/2, pi/2).
// ----------------------------------------------------------------------------
module lp2c_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lp2c_pkg::lp2c_cfg_t           cfg,
    input  logic                          in_vld,
    output logic                          in_rdy,
    input  logic [lp2c_pkg::RW-1:0]       in_range,
    input  logic                          in_finite,
    input  logic                          in_last,
    output logic                          out_vld,
    input  logic                          out_rdy,
    output logic signed [lp2c_pkg::XW-1:0] out_x,
    output logic [lp2c_pkg::ZW-1:0]       out_z,
    output lp2c_pkg::lp2c_tag_t           out_tag
);
    import lp2c_pkg::*;

    logic [ZW-1:0]  beam_angle_reg, beam_angle_next;
    logic           at_start_reg;
    logic [ZW-1:0]  cur_angle;
    logic           range_ok;
    logic [RW+31:0] product;

    logic           a_vld_reg;
    logic [PW-1:0]  a_mag_reg;
    logic [ZW-1:0]  a_ang_reg;
    lp2c_tag_t      a_tag_reg;
    logic           a_rdy;

    logic                 b_vld_reg;
    logic signed [XW-1:0] b_x_reg, b_x_next;
    logic [ZW-1:0]        b_z_reg, b_z_next;
    lp2c_tag_t            b_tag_reg;
    logic                 b_rdy;
    logic                 fold;

    assign cur_angle       = at_start_reg ? cfg.start_angle : beam_angle_reg;
    assign beam_angle_next = cur_angle + cfg.angle_step;
    assign range_ok        = in_finite && (in_range >= cfg.min_range)
                             && (in_range <= cfg.max_range);
    assign product         = {8'd0, in_range} * {{RW{1'b0}}, GAIN_Q32};

    assign b_rdy  = !b_vld_reg || out_rdy;
    assign a_rdy  = !a_vld_reg || b_rdy;
    assign in_rdy = a_rdy;

    // Fold angles in the left half plane by half a turn and flip the vector
    assign fold     = (a_ang_reg[31:30] == 2'b01) || (a_ang_reg[31:30] == 2'b10);
    assign b_z_next = fold ? (a_ang_reg + HALF_TURN) : a_ang_reg;
    assign b_x_next = fold ? -$signed({{(XW-PW){1'b0}}, a_mag_reg})
                           :  $signed({{(XW-PW){1'b0}}, a_mag_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_angle_reg <= '0;
            at_start_reg   <= 1'b1;
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
        end
        else
        begin
            if (in_vld && a_rdy)
            begin
                beam_angle_reg <= beam_angle_next;
                at_start_reg   <= in_last;
            end
            if (a_rdy)
                a_vld_reg <= in_vld;
            if (b_rdy)
                b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld && a_rdy)
        begin
            a_mag_reg       <= product[RW+31:16];
            a_ang_reg       <= cur_angle;
            a_tag_reg.pt_ok <= range_ok;
            a_tag_reg.last  <= in_last;
        end
        if (a_vld_reg && b_rdy)
        begin
            b_x_reg   <= b_x_next;
            b_z_reg   <= b_z_next;
            b_tag_reg <= a_tag_reg;
        end
    end

    assign out_vld = b_vld_reg;
    assign out_x   = b_x_reg;
    assign out_z   = b_z_reg;
    assign out_tag = b_tag_reg;

endmodule

@@ rtl/lp2c_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_cell: one CORDIC rotation micro-step
// Shift-add rotation by atan(2^-IDX), holding its result for the next cell.
// ----------------------------------------------------------------------------
module lp2c_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_vld,
    output logic                           in_rdy,
    input  logic signed [lp2c_pkg::XW-1:0] in_x,
    input  logic signed [lp2c_pkg::XW-1:0] in_y,
    input  logic [lp2c_pkg::ZW-1:0]        in_z,
    input  lp2c_pkg::lp2c_tag_t            in_tag,
    output logic                           out_vld,
    input  logic                           out_rdy,
    output logic signed [lp2c_pkg::XW-1:0] out_x,
    output logic signed [lp2c_pkg::XW-1:0] out_y,
    output logic [lp2c_pkg::ZW-1:0]        out_z,
    output lp2c_pkg::lp2c_tag_t            out_tag
);
    import lp2c_pkg::*;

    localparam logic [ZW-1:0] ATAN = lp2c_atan(5'(IDX));

    logic                 vld_reg;
    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic [ZW-1:0]        z_reg, z_next;
    lp2c_tag_t            tag_reg;

    assign in_rdy = !vld_reg || out_rdy;
    assign dx     = in_y >>> IDX;
    assign dy     = in_x >>> IDX;

    // Rotate toward zero residual angle
    always_comb
    begin
        if (!in_z[ZW-1])
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN;
        end
        else
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_rdy)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (in_vld && in_rdy)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= in_tag;
        end
    end

    assign out_vld = vld_reg;
    assign out_x   = x_reg;
    assign out_y   = y_reg;
    assign out_z   = z_reg;
    assign out_tag = tag_reg;

endmodule

@@ rtl/lp2c_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_out: rounding, saturation and output register
// Drops the extra fraction bits, clamps to the coordinate range, zeroes rejects.
// ----------------------------------------------------------------------------
module lp2c_out (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_vld,
    output logic                           in_rdy,
    input  logic signed [lp2c_pkg::XW-1:0] in_x,
    input  logic signed [lp2c_pkg::XW-1:0] in_y,
    input  lp2c_pkg::lp2c_tag_t            in_tag,
    output logic                           out_vld,
    input  logic                           out_rdy,
    output logic signed [lp2c_pkg::OW-1:0] out_x,
    output logic signed [lp2c_pkg::OW-1:0] out_y,
    output lp2c_pkg::lp2c_tag_t            out_tag
);
    import lp2c_pkg::*;

    logic                 vld_reg;
    logic signed [OW-1:0] x_reg, y_reg, x_next, y_next;
    lp2c_tag_t            tag_reg;

    function automatic logic signed [OW-1:0] round_sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] sum;
        logic signed [TW-1:0] t;
        sum = v + XW'(32768);
        t   = TW'(sum >>> 16);
        if (t > OUT_LIMIT)
            return OW'(OUT_LIMIT);
        else if (t < -OUT_LIMIT)
            return OW'(-OUT_LIMIT);
        else
            return OW'(t);
    endfunction

    assign in_rdy = !vld_reg || out_rdy;
    assign x_next = in_tag.pt_ok ? round_sat(in_x) : '0;
    assign y_next = in_tag.pt_ok ? round_sat(in_y) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_rdy)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (in_vld && in_rdy)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            tag_reg <= in_tag;
        end
    end

    assign out_vld = vld_reg;
    assign out_x   = x_reg;
    assign out_y   = y_reg;
    assign out_tag = tag_reg;

endmodule

@@ rtl/lidar_polar_to_cartesian_unit.sv @@
`timescale 1ns / 1ps
// Throughput: one sample per clock unless the output stalls; every stage is one
// register deep. A stage whose output is empty takes new data even while a later
// stage stalls.
// Reset (rst_n low, asynchronous) empties the pipeline, restarts the scan angle
// and loads start_angle = 0, angle_step = 0, min_range = 0, max_range = all ones.
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian_unit: lidar range samples to x/y points
// Tracks the beam angle per scan, gates samples by a range window and rotates
// the range vector through a pipelined, gain-corrected CORDIC cell chain.
// ----------------------------------------------------------------------------
module lidar_polar_to_cartesian_unit #(
    parameter int CORDIC_STAGES = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // sample stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] range_value
    input  logic        s_axis_tuser,   // [0] range_finite
    input  logic        s_axis_tlast,   // scan_end
    // point stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [24:0] point_x, [49:25] point_y, [55:50] zero
    output logic        m_axis_tuser,   // [0] point_valid
    output logic        m_axis_tlast    // scan_done
);
    import lp2c_pkg::*;

    // More than 32 micro-steps add nothing: the arctangent table runs out
    localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    lp2c_cfg_t cfg_reg;

    // Configuration registers; the user must write them only while the pipeline is idle, unchecked by the block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_angle <= '0;
            cfg_reg.angle_step  <= '0;
            cfg_reg.min_range   <= '0;
            cfg_reg.max_range   <= '1;
        end
        else if (cfg_we)
        begin
            case (lp2c_reg_t'(cfg_addr))
                REG_START_ANGLE: cfg_reg.start_angle <= cfg_wdata;
                REG_ANGLE_STEP:  cfg_reg.angle_step  <= cfg_wdata;
                REG_MIN_RANGE:   cfg_reg.min_range   <= cfg_wdata[RW-1:0];
                REG_MAX_RANGE:   cfg_reg.max_range   <= cfg_wdata[RW-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Chain taps: entry 0 is the front end, entry NS the last cell
    logic                 c_vld [NS+1];
    logic                 c_rdy [NS+1];
    logic signed [XW-1:0] c_x   [NS+1];
    logic signed [XW-1:0] c_y   [NS+1];
    logic [ZW-1:0]        c_z   [NS+1];
    lp2c_tag_t            c_tag [NS+1];

    logic signed [OW-1:0] pt_x, pt_y;
    lp2c_tag_t            pt_tag;

    lp2c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_vld    (s_axis_tvalid),
        .in_rdy    (s_axis_tready),
        .in_range  (s_axis_tdata[RW-1:0]),
        .in_finite (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .out_vld   (c_vld[0]),
        .out_rdy   (c_rdy[0]),
        .out_x     (c_x[0]),
        .out_z     (c_z[0]),
        .out_tag   (c_tag[0])
    );

    // The start vector lies on the x axis
    assign c_y[0] = '0;

    // One cell per micro-rotation; data advances one cell per clock unless a later cell stalls
    for (genvar i = 0; i < NS; i++)
    begin : g_cell
        lp2c_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (c_vld[i]),
            .in_rdy  (c_rdy[i]),
            .in_x    (c_x[i]),
            .in_y    (c_y[i]),
            .in_z    (c_z[i]),
            .in_tag  (c_tag[i]),
            .out_vld (c_vld[i+1]),
            .out_rdy (c_rdy[i+1]),
            .out_x   (c_x[i+1]),
            .out_y   (c_y[i+1]),
            .out_z   (c_z[i+1]),
            .out_tag (c_tag[i+1])
        );
    end

    // The residual angle of the last cell is not needed past here
    lp2c_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (c_vld[NS] && (c_z[NS] == c_z[NS])),
        .in_rdy  (c_rdy[NS]),
        .in_x    (c_x[NS]),
        .in_y    (c_y[NS]),
        .in_tag  (c_tag[NS]),
        .out_vld (m_axis_tvalid),
        .out_rdy (m_axis_tready),
        .out_x   (pt_x),
        .out_y   (pt_y),
        .out_tag (pt_tag)
    );

    assign m_axis_tdata = {6'd0, pt_y, pt_x};
    assign m_axis_tuser = pt_tag.pt_ok;
    assign m_axis_tlast = pt_tag.last;

endmodule

@@ rtl/lp2c_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_checker: port-level checks for the lidar polar-to-cartesian unit
// Watches the output stream for stalls, rejected points and coordinate range.
// ----------------------------------------------------------------------------
module lp2c_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // Hold a stalled point unchanged until it transfers
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
        && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // A rejected sample carries zero coordinates
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 56'd0)
        else $error("rejected sample with nonzero coordinates");

    // Saturation never yields the most negative code; padding stays zero
    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[24:0] != 25'h1000000
        && m_axis_tdata[49:25] != 25'h1000000 && m_axis_tdata[55:50] == 6'd0)
        else $error("coordinate out of saturation range");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

endmodule

bind lidar_polar_to_cartesian_unit lp2c_checker u_lp2c_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ sim/lp2c_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_point_checker: point predictor and scoreboard for the polar-to-cartesian unit
// Watches the register port and both streams, tracks the scan angle on its
// own, predicts each point at the sample transfer and compares it with the
// point transfer that comes out of the block, in order.
// ----------------------------------------------------------------------------
module lp2c_point_checker #(
    parameter int CORDIC_STAGES = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] range_value
    input  logic        s_axis_tuser,   // [0] range_finite
    input  logic        s_axis_tlast,   // scan_end
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // [24:0] point_x, [49:25] point_y, [55:50] zero
    input  logic        m_axis_tuser,   // [0] point_valid
    input  logic        m_axis_tlast,   // scan_done
    output int          fail_count,
    output int          points_pending
);

    import lp2c_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [24:0] x;
        logic [24:0] y;
        logic        done;
    } point_t;

    // atan(2^-i) in binary angle units, rounded to nearest
    localparam logic [31:0] ARCTAN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };
    localparam logic [63:0] CORDIC_GAIN = 64'h0000_0000_9B74_EDA8;

    logic [31:0] start_angle;
    logic [31:0] angle_step;
    logic [23:0] min_range;
    logic [23:0] max_range;
    logic [31:0] beam_angle;
    logic        at_scan_start;

    point_t points_due[$];
    int     errors = 0;
    int     due_count = 0;
    int     points_seen = 0;

    assign fail_count     = errors;
    assign points_pending = due_count;

    function automatic logic [24:0] round_clamp(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + 64'sd32768) >>> 16;
        if (t > 64'sd16777215)
            t = 64'sd16777215;
        else if (t < -64'sd16777215)
            t = -64'sd16777215;
        return t[24:0];
    endfunction

    // Predict one point and advance the scan angle
    function automatic point_t next_point(input logic [23:0] r, input logic finite,
                                          input logic last);
        point_t             p;
        logic [31:0]        ang;
        logic [31:0]        z;
        logic [63:0]        prod;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        int                 n;
        ang = at_scan_start ? start_angle : beam_angle;
        p.ok = finite && (r >= min_range) && (r <= max_range);
        p.x = '0;
        p.y = '0;
        p.done = last;
        if (p.ok)
        begin
            prod = {40'd0, r} * CORDIC_GAIN;
            x = $signed(prod >> 16);
            y = '0;
            z = ang;
            // fold the left half-plane onto the right one
            if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10)
            begin
                z = ang + 32'h8000_0000;
                x = -x;
            end
            n = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
            for (int i = 0; i < n; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (!z[31])
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARCTAN[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARCTAN[i];
                end
            end
            p.x = round_clamp(x);
            p.y = round_clamp(y);
        end
        beam_angle = ang + angle_step;
        at_scan_start = last;
        return p;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("MISMATCH point %0d %s: expected 0x%0h, got 0x%0h",
                 points_seen, field, want, got);
        errors = errors + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
        begin
            start_angle   = '0;
            angle_step    = '0;
            min_range     = '0;
            max_range     = 24'hFF_FFFF;
            beam_angle    = '0;
            at_scan_start = 1'b1;
            points_due.delete();
            due_count     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_START_ANGLE: start_angle = cfg_wdata;
                    REG_ANGLE_STEP:  angle_step  = cfg_wdata;
                    REG_MIN_RANGE:   min_range   = cfg_wdata[23:0];
                    REG_MAX_RANGE:   max_range   = cfg_wdata[23:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (points_due.size() == 0)
                    report_mismatch("unexpected point", 64'd0, 64'(m_axis_tdata));
                else
                begin
                    want = points_due.pop_front();
                    if (m_axis_tuser !== want.ok)
                        report_mismatch("point_valid", 64'(want.ok), 64'(m_axis_tuser));
                    if (m_axis_tdata[24:0] !== want.x)
                        report_mismatch("point_x", 64'(want.x), 64'(m_axis_tdata[24:0]));
                    if (m_axis_tdata[49:25] !== want.y)
                        report_mismatch("point_y", 64'(want.y), 64'(m_axis_tdata[49:25]));
                    if (m_axis_tdata[55:50] !== 6'd0)
                        report_mismatch("tdata padding", 64'd0, 64'(m_axis_tdata[55:50]));
                    if (m_axis_tlast !== want.done)
                        report_mismatch("scan_done", 64'(want.done), 64'(m_axis_tlast));
                end
                points_seen = points_seen + 1;
            end
            if (s_axis_tvalid && s_axis_tready)
                points_due = {points_due,
                              next_point(s_axis_tdata, s_axis_tuser, s_axis_tlast)};
            due_count = points_due.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the lidar polar-to-cartesian unit
// Drives directed and random range samples under several idle/stall mixes and
// register settings; the checker beside the block predicts and compares every
// point, and this module reports the outcome.
// ----------------------------------------------------------------------------
module tb_top;

    import lp2c_pkg::*;

    localparam int CORDIC_STAGES = 20;
    localparam int LATENCY       = CORDIC_STAGES + 3;
    localparam int QUIET_LIMIT   = 5000;   // cycles without any transfer
    localparam int RANDOM_ITEMS  = 900;
    localparam int PHASES        = 4;
    localparam int HOLD_CYCLES   = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // [23:0] range_value
    logic        s_axis_tuser = 1'b0;  // [0] range_finite
    logic        s_axis_tlast = 1'b0;  // scan_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // [24:0] point_x, [49:25] point_y, [55:50] zero
    logic        m_axis_tuser;         // [0] point_valid
    logic        m_axis_tlast;         // scan_done

    int fail_count;
    int points_pending;

    // Idle mix, changed per phase
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    // Receiver hold-off request; the receiver process takes it and counts it down
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;

    // Window currently programmed, used to aim ranges at its edges
    logic [23:0] win_min = '0;
    logic [23:0] win_max = 24'hFF_FFFF;

    lidar_polar_to_cartesian_unit #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lp2c_point_checker #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) point_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .fail_count     (fail_count),
        .points_pending (points_pending)
    );

    always #5 clk = ~clk;

    // Receiver: random stalls, or a long hold-off when one is requested.
    // Only this process drives tready, once per falling edge.
    always @(negedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left = rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offer one sample; called at a falling edge and returns at one.
    // Valid stays high into the next call so back-to-back transfers happen.
    task automatic send_sample(input logic [23:0] r, input logic finite, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        s_axis_tuser  <= finite;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering, wait for every predicted point, then let the pipe settle
    task automatic drain_points();
        s_axis_tvalid <= 1'b0;
        while (points_pending != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_reg(input lp2c_reg_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Program all four registers; only called with the block idle
    task automatic set_scan_config(input logic [31:0] first_angle, input logic [31:0] step,
                                   input logic [23:0] lo, input logic [23:0] hi);
        write_reg(REG_START_ANGLE, first_angle);
        write_reg(REG_ANGLE_STEP, step);
        write_reg(REG_MIN_RANGE, {8'd0, lo});
        write_reg(REG_MAX_RANGE, {8'd0, hi});
        win_min = lo;
        win_max = hi;
    endtask

    // Ranges: mostly uniform, with a share aimed at the window edges and the extremes
    function automatic logic [23:0] pick_range();
        logic [23:0] r;
        case ($urandom_range(9))
            4:       r = win_min + 24'($urandom_range(2)) - 24'd1;
            5:       r = win_max + 24'($urandom_range(2)) - 24'd1;
            6:       r = 24'($urandom_range(255));
            7:       r = 24'hFF_FFFF - 24'($urandom_range(15));
            default: r = 24'($urandom);
        endcase
        return r;
    endfunction

    initial
    begin
        logic [23:0] lo;
        logic [23:0] hi;
        logic [23:0] tmp;
        // Assert reset as an update at time zero so the asynchronous reset edges fire
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset settings, range extremes, non-finite sample
        send_sample(24'h00_0000, 1'b1, 1'b0);
        send_sample(24'hFF_FFFF, 1'b1, 1'b0);
        send_sample(24'hFF_FFFF, 1'b0, 1'b0);
        send_sample(24'h80_0000, 1'b1, 1'b1);
        drain_points();

        // Quarter-turn steps from just below half a turn: hits every quadrant
        // boundary and wraps the angle; ranges sit on both sides of each window edge
        set_scan_config(32'h7FFF_FFFF, 32'h4000_0000, 24'h00_0100, 24'hFF_FF00);
        send_sample(24'hFF_FFFF, 1'b1, 1'b0);
        send_sample(24'hFF_FF00, 1'b1, 1'b0);
        send_sample(24'h00_0100, 1'b1, 1'b0);
        send_sample(24'h00_00FF, 1'b1, 1'b0);
        send_sample(24'hA5_A5A5, 1'b1, 1'b0);
        drain_points();

        // Change registers mid-scan with an empty window; then a one-sample scan
        set_scan_config(32'h8000_0000, 32'h8000_0000, 24'h80_0000, 24'h7F_FFFF);
        send_sample(24'h80_0000, 1'b1, 1'b0);
        send_sample(24'h7F_FFFF, 1'b1, 1'b1);
        send_sample(24'h00_0000, 1'b0, 1'b1);
        drain_points();

        set_scan_config(32'hC000_0000, 32'hFFFF_FFFF, 24'h00_0000, 24'hFF_FFFF);
        send_sample(24'hFF_FFFF, 1'b1, 1'b0);
        send_sample(24'hFF_FFFF, 1'b1, 1'b0);
        send_sample(24'h00_0001, 1'b1, 1'b0);
        send_sample(24'h5A_5A5A, 1'b1, 1'b1);
        send_sample(24'hFF_FFFF, 1'b1, 1'b1);
        drain_points();

        // Window of a single value: zero
        set_scan_config(32'h4000_0000, 32'h0000_0001, 24'h00_0000, 24'h00_0000);
        send_sample(24'h00_0000, 1'b1, 1'b0);
        send_sample(24'h00_0001, 1'b1, 1'b1);

        // Random phases: free flow, sender idle, receiver stalling, both
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_points();
            case (phase)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                    set_scan_config($urandom, $urandom, 24'h00_0000, 24'hFF_FFFF);
                end
                1:
                begin
                    tx_idle_pct = 68;
                    rx_stall_pct = 0;
                    set_scan_config(32'h8000_0000, 32'h7FFF_FFFF,
                                    24'($urandom_range(24'h3F_FFFF)),
                                    24'($urandom_range(24'hFF_FFFF, 24'hC0_0000)));
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 68;
                    set_scan_config(32'hFFFF_FFFF, $urandom,
                                    24'($urandom_range(255)), 24'hFF_FFFF);
                end
                default:
                begin
                    tx_idle_pct = 22;
                    rx_stall_pct = 22;
                    lo = 24'($urandom);
                    hi = 24'($urandom);
                    if (lo > hi)
                    begin
                        tmp = lo;
                        lo = hi;
                        hi = tmp;
                    end
                    set_scan_config($urandom, $urandom, lo, hi);
                end
            endcase
            for (int k = 0; k < RANDOM_ITEMS / PHASES; k++)
            begin
                // Long receiver hold-off while samples keep coming: fills the pipe
                if (phase == 0 && k == 40)
                    rx_hold_req = HOLD_CYCLES;
                // Sender pause until the pipe is empty, mid-phase
                if (phase == PHASES - 1 && k == 100)
                    drain_points();
                send_sample(pick_range(), ($urandom_range(99) < 85),
                            ($urandom_range(15) == 0));
            end
        end

        drain_points();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
